// ===== rtl/mds_pkg.sv =====
// Shared types and constants for the saturating multiply-divide core.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package mds_pkg;

   // Width of each request and response data port
   localparam int FIELD_WIDTH = 64;

   // Default operand width (legal range 8 to FIELD_WIDTH)
   localparam int OPERAND_WIDTH_DEFAULT = 64;

   // Control travelling with each request down the pipeline
   typedef struct packed {
      logic valid;
      logic overflow;
      logic div_zero;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/mds_mult.sv =====
// Two-stage full-width multiplier: partial products, then their sum.
// Depends on mds_pkg for the control struct.
`default_nettype none

module mds_mult #(
   parameter int OPERAND_WIDTH = mds_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         valid_in,
   input  wire logic [OPERAND_WIDTH-1:0]     a_in,
   input  wire logic [OPERAND_WIDTH-1:0]     b_in,
   input  wire logic [OPERAND_WIDTH-1:0]     d_in,
   output mds_pkg::ctl_type                  ctl_out,
   output logic      [2*OPERAND_WIDTH-1:0]   prod_out,
   output logic      [OPERAND_WIDTH-1:0]     d_out
);

   localparam int W    = OPERAND_WIDTH;
   localparam int HALF = (W + 1) / 2;
   localparam int HW   = W - HALF;
   localparam int PW   = 2 * W;

   logic              valid_a_ff, valid_b_ff;
   logic [2*HALF-1:0] ll_ff, ll_in;
   logic [W-1:0]      hl_ff, hl_in;
   logic [W-1:0]      lh_ff, lh_in;
   logic [2*HW-1:0]   hh_ff, hh_in;
   logic [W-1:0]      d_a_ff, d_b_ff;
   logic [PW-1:0]     prod_ff, prod_in;

   always_comb begin
      ll_in = (2*HALF)'(a_in[HALF-1:0]) * (2*HALF)'(b_in[HALF-1:0]);
      hl_in = W'(a_in[W-1:HALF]) * W'(b_in[HALF-1:0]);
      lh_in = W'(a_in[HALF-1:0]) * W'(b_in[W-1:HALF]);
      hh_in = (2*HW)'(a_in[W-1:HALF]) * (2*HW)'(b_in[W-1:HALF]);
   end

   assign prod_in = PW'(ll_ff) + (PW'(hl_ff) << HALF) + (PW'(lh_ff) << HALF)
                  + (PW'(hh_ff) << (2*HALF));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_in;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      hl_ff   <= hl_in;
      lh_ff   <= lh_in;
      hh_ff   <= hh_in;
      d_a_ff  <= d_in;
      prod_ff <= prod_in;
      d_b_ff  <= d_a_ff;
   end

   always_comb begin
      ctl_out          = '0;
      ctl_out.valid    = valid_b_ff;
   end
   assign prod_out = prod_ff;
   assign d_out    = d_b_ff;

endmodule

`default_nettype wire

// ===== rtl/mds_div_step.sv =====
// One registered restoring-division step: yields one quotient bit.
// Depends on mds_pkg for the control struct.
`default_nettype none

module mds_div_step #(
   parameter int OPERAND_WIDTH = mds_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mds_pkg::ctl_type         ctl_in,
   input  wire logic [OPERAND_WIDTH-1:0] rem_in,
   input  wire logic [OPERAND_WIDTH-1:0] low_in,
   input  wire logic [OPERAND_WIDTH-1:0] d_in,
   input  wire logic [OPERAND_WIDTH-1:0] quot_in,
   output mds_pkg::ctl_type              ctl_out,
   output logic      [OPERAND_WIDTH-1:0] rem_out,
   output logic      [OPERAND_WIDTH-1:0] low_out,
   output logic      [OPERAND_WIDTH-1:0] d_out,
   output logic      [OPERAND_WIDTH-1:0] quot_out
);

   localparam int W = OPERAND_WIDTH;

   mds_pkg::ctl_type ctl_ff;
   logic [W:0]       trial, diff;
   logic             take;
   logic [W-1:0]     rem_ff, rem_in_n;
   logic [W-1:0]     low_ff, d_ff, quot_ff;

   // bring down the next dividend bit and try the subtraction
   always_comb begin
      trial    = {rem_in, low_in[W-1]};
      diff     = trial - {1'b0, d_in};
      take     = (trial >= {1'b0, d_in});
      rem_in_n = take ? diff[W-1:0] : trial[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in_n;
      low_ff  <= {low_in[W-2:0], 1'b0};
      d_ff    <= d_in;
      quot_ff <= {quot_in[W-2:0], take};
   end

   assign ctl_out  = ctl_ff;
   assign rem_out  = rem_ff;
   assign low_out  = low_ff;
   assign d_out    = d_ff;
   assign quot_out = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/mul_div_64_saturating_core.sv =====
// Top level: floor(multiplicand * multiplier / divisor), saturating.
// Depends on mds_pkg, mds_mult and mds_div_step.
//
// Channel   Ports                                         Direction  Handshake
// request   start, busy, req_multiplicand/multiplier/     in         start && !busy
//           req_divisor
// response  rsp_valid, rsp_quotient, rsp_overflow,        out        rsp_valid strobe
//           rsp_divide_by_zero
//
// The pipeline has two multiplier stages, one overflow check stage, one stage per
// quotient bit and an output register. A new request may be taken every cycle,
// so busy stays low.
// Reset clears only the valid bits and pipeline control flags; data registers hold whatever they had.
// The receiver cannot stall, so the pipeline always advances.
`default_nettype none

module mul_div_64_saturating_core #(
   parameter int OPERAND_WIDTH = mds_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [mds_pkg::FIELD_WIDTH-1:0] req_multiplicand,
   input  wire logic [mds_pkg::FIELD_WIDTH-1:0] req_multiplier,
   input  wire logic [mds_pkg::FIELD_WIDTH-1:0] req_divisor,
   output logic                                 rsp_valid,
   output logic      [mds_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic                                 rsp_overflow,
   output logic                                 rsp_divide_by_zero
);

   localparam int W       = OPERAND_WIDTH;
   localparam int FW      = mds_pkg::FIELD_WIDTH;
   localparam int LATENCY = W + 4;
   localparam logic [FW-1:0] SAT_VALUE = FW'((65'd1 << W) - 65'd1);

   mds_pkg::ctl_type mult_ctl;
   logic [2*W-1:0]   mult_prod;
   logic [W-1:0]     mult_d;

   mds_pkg::ctl_type chk_ctl_ff, chk_ctl_in;
   logic [W-1:0]     chk_hi_ff, chk_lo_ff, chk_d_ff;

   mds_pkg::ctl_type step_ctl  [W+1];
   logic [W-1:0]     step_rem  [W+1];
   logic [W-1:0]     step_low  [W+1];
   logic [W-1:0]     step_d    [W+1];
   logic [W-1:0]     step_quot [W+1];

   logic            rsp_valid_ff;
   logic [FW-1:0]   rsp_quotient_ff, rsp_quotient_in;
   logic            rsp_overflow_ff, rsp_div_zero_ff;

   assign busy = 1'b0;

   mds_mult #(
      .OPERAND_WIDTH (W)
   ) u_mult (
      .clock    (clock),
      .reset    (reset),
      .valid_in (start && !busy),
      .a_in     (req_multiplicand[W-1:0]),
      .b_in     (req_multiplier[W-1:0]),
      .d_in     (req_divisor[W-1:0]),
      .ctl_out  (mult_ctl),
      .prod_out (mult_prod),
      .d_out    (mult_d)
   );

   // classify: zero divisor first, then a quotient that cannot fit
   always_comb begin
      chk_ctl_in          = mult_ctl;
      chk_ctl_in.div_zero = (mult_d == '0);
      chk_ctl_in.overflow = (mult_d != '0) && (mult_prod[2*W-1:W] >= mult_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ctl_ff <= '0;
      end else begin
         chk_ctl_ff <= chk_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_hi_ff <= mult_prod[2*W-1:W];
      chk_lo_ff <= mult_prod[W-1:0];
      chk_d_ff  <= mult_d;
   end

   assign step_ctl[0]  = chk_ctl_ff;
   assign step_rem[0]  = chk_hi_ff;
   assign step_low[0]  = chk_lo_ff;
   assign step_d[0]    = chk_d_ff;
   assign step_quot[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_step
      mds_div_step #(
         .OPERAND_WIDTH (W)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (step_ctl[i]),
         .rem_in   (step_rem[i]),
         .low_in   (step_low[i]),
         .d_in     (step_d[i]),
         .quot_in  (step_quot[i]),
         .ctl_out  (step_ctl[i+1]),
         .rem_out  (step_rem[i+1]),
         .low_out  (step_low[i+1]),
         .d_out    (step_d[i+1]),
         .quot_out (step_quot[i+1])
      );
   end

   // remainder is not returned; drop it at the end of the chain
   always_comb begin
      if (step_ctl[W].overflow || step_ctl[W].div_zero) begin
         rsp_quotient_in = SAT_VALUE;
      end else begin
         rsp_quotient_in = FW'(step_quot[W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= step_ctl[W].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_quotient_ff <= rsp_quotient_in;
      rsp_overflow_ff <= step_ctl[W].overflow;
      rsp_div_zero_ff <= step_ctl[W].div_zero;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quotient_ff;
   assign rsp_overflow       = rsp_overflow_ff;
   assign rsp_divide_by_zero = rsp_div_zero_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("request did not produce a response after the pipeline latency");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_divide_by_zero))
      else $error("overflow and divide-by-zero raised together");

   a_saturate : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_overflow || rsp_divide_by_zero) |-> rsp_quotient == SAT_VALUE)
      else $error("flagged response did not saturate the quotient");

endmodule

`default_nettype wire

// ===== tb/mul_div_64_saturating_core_tb.sv =====
// Self-checking bench for mul_div_64_saturating_core: predicts floor(a*b/d) with saturation.
// A clocked driver feeds requests from a queue and a clocked monitor checks each response.
// Depends on mds_pkg and the core under rtl/.
`timescale 1ns / 1ps

module mul_div_64_saturating_core_tb;

   localparam int W = mds_pkg::FIELD_WIDTH;
   localparam logic [W-1:0] ALL_ONES = '1;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 175;

   typedef struct packed {
      logic [W-1:0] multiplicand;
      logic [W-1:0] multiplier;
      logic [W-1:0] divisor;
   } muldiv_req_type;

   typedef struct packed {
      logic [W-1:0] quotient;
      logic         overflow;
      logic         divide_by_zero;
   } muldiv_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [W-1:0] req_multiplicand = '0;
   logic [W-1:0] req_multiplier = '0;
   logic [W-1:0] req_divisor = '0;
   logic         rsp_valid;
   logic [W-1:0] rsp_quotient;
   logic         rsp_overflow;
   logic         rsp_divide_by_zero;

   muldiv_req_type pending_requests[$];
   muldiv_rsp_type quotient_expected[$];
   int             sender_idle_pct = 0;
   int             mismatch_count = 0;
   int             failure_count = 0;

   mul_div_64_saturating_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_multiplicand   (req_multiplicand),
      .req_multiplier     (req_multiplier),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #5 clock = ~clock;

   function automatic muldiv_rsp_type predict_muldiv(muldiv_req_type r);
      logic [2*W-1:0] product;
      muldiv_rsp_type e;
      product = {{W{1'b0}}, r.multiplicand} * {{W{1'b0}}, r.multiplier};
      e = '0;
      if (r.divisor == '0) begin
         e.quotient = ALL_ONES;
         e.divide_by_zero = 1'b1;
      end else if (product[2*W-1:W] >= r.divisor) begin
         e.quotient = ALL_ONES;
         e.overflow = 1'b1;
      end else begin
         e.quotient = W'(product / {{W{1'b0}}, r.divisor});
      end
      return e;
   endfunction

   function automatic logic [W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // random word of random magnitude
   function automatic logic [W-1:0] rand_scaled();
      return rand_word() >> $urandom_range(0, W - 1);
   endfunction

   function automatic muldiv_req_type rand_request();
      muldiv_req_type r;
      logic [2*W-1:0] product;
      logic [W-1:0]   high;
      r.multiplicand = ($urandom_range(0, 3) == 0) ? rand_word() : rand_scaled();
      r.multiplier   = ($urandom_range(0, 3) == 0) ? rand_word() : rand_scaled();
      product = {{W{1'b0}}, r.multiplicand} * {{W{1'b0}}, r.multiplier};
      high = product[2*W-1:W];
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            // divisor above the high half, so the quotient fits (any divisor if the high half is all ones)
            if (high == ALL_ONES) r.divisor = rand_word();
            else r.divisor = high + 1 + (rand_word() % ~high);
         end
         5: r.divisor = high;
         6: r.divisor = (high == ALL_ONES) ? ALL_ONES : high + 1;
         7: begin
            r.multiplicand = rand_word();
            r.multiplier = rand_word();
            r.divisor = rand_word();
         end
         8: r.divisor = '0;
         default: begin
            r.multiplicand = rand_word() >> $urandom_range(W / 2, W - 1);
            r.multiplier = rand_word() >> $urandom_range(W / 2, W - 1);
            r.divisor = W'($urandom_range(1, 255));
         end
      endcase
      return r;
   endfunction

   task automatic add_request(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] d);
      muldiv_req_type r;
      r.multiplicand = a;
      r.multiplier = b;
      r.divisor = d;
      pending_requests.push_back(r);
   endtask

   // hold until every queued request is accepted and every response is back
   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() != 0 || start || quotient_expected.size() != 0)
         @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin : drive
      muldiv_req_type cur;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cur.multiplicand = req_multiplicand;
            cur.multiplier = req_multiplier;
            cur.divisor = req_divisor;
            quotient_expected.push_back(predict_muldiv(cur));
            void'(pending_requests.pop_front());
         end
         if (start && busy) begin
            // hold the request until it is taken
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            req_multiplicand <= pending_requests[0].multiplicand;
            req_multiplier   <= pending_requests[0].multiplier;
            req_divisor      <= pending_requests[0].divisor;
            start            <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      muldiv_rsp_type e;
      if (!reset && rsp_valid) begin
         if (quotient_expected.size() == 0) begin
            failure_count++;
            if (failure_count + mismatch_count <= MAX_REPORTS)
               $display("unexpected response: quotient=%h overflow=%b divide_by_zero=%b",
                        rsp_quotient, rsp_overflow, rsp_divide_by_zero);
         end else begin
            e = quotient_expected.pop_front();
            if (rsp_quotient !== e.quotient || rsp_overflow !== e.overflow ||
                rsp_divide_by_zero !== e.divide_by_zero) begin
               mismatch_count++;
               if (failure_count + mismatch_count <= MAX_REPORTS)
                  $display("mismatch: quotient exp %h got %h, overflow exp %b got %b,",
                           e.quotient, rsp_quotient, e.overflow, rsp_overflow,
                           " divide_by_zero exp %b got %b",
                           e.divide_by_zero, rsp_divide_by_zero);
            end
         end
      end
   end

   initial begin : stimulus
      int phase_idle[4];
      phase_idle = '{0, 51, 0, 31};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      add_request('0, '0, '0);
      add_request('0, '0, 64'd1);
      add_request('0, ALL_ONES, ALL_ONES);
      add_request(ALL_ONES, ALL_ONES, '0);
      add_request(64'd7, 64'd9, '0);
      add_request(ALL_ONES, ALL_ONES, ALL_ONES);
      add_request(ALL_ONES, ALL_ONES, ALL_ONES - 1);
      add_request(ALL_ONES, ALL_ONES, 64'd1);
      add_request(64'd1, 64'd1, 64'd1);
      add_request(64'd1, ALL_ONES, 64'd1);
      add_request(ALL_ONES, 64'd1, 64'd2);
      add_request(64'h8000_0000_0000_0000, 64'd2, 64'd1);
      add_request(64'h8000_0000_0000_0000, 64'd2, 64'd2);
      add_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h8000_0000_0000_0000);
      add_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h8000_0000_0000_0000 + 1);
      add_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h4000_0000_0000_0000);
      add_request(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000, 64'd3);
      add_request(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
      add_request(64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321,
                  64'h0123_4567_89AB_CDEF);
      add_request(64'd1000, 64'd1000, 64'd7);
      add_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h3FFF_FFFF_FFFF_FFFF);
      add_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, ALL_ONES);

      foreach (phase_idle[p]) begin
         @(negedge clock);
         sender_idle_pct = phase_idle[p];
         repeat (ITEMS_PER_PHASE) pending_requests.push_back(rand_request());
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (quotient_expected.size() != 0) failure_count++;
      if (mismatch_count == 0 && failure_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mds_pkg.sv
rtl/mds_mult.sv
rtl/mds_div_step.sv
rtl/mul_div_64_saturating_core.sv
tb/mul_div_64_saturating_core_tb.sv
